FILE: rtl/sms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants of the sliding Mahalanobis score unit.
package sms_pkg;

  localparam int KIND_W   = 2;
  localparam int SAMPLE_W = 16;
  localparam int IDX_W    = 3;
  localparam int LOAD_W   = 20;
  localparam int OFF_W    = 5;
  localparam int MAT_W    = 20;
  localparam int DEV_W    = SAMPLE_W + 1;
  localparam int SCORE_W  = 64;
  localparam int TAPS_W   = 4;

  localparam logic [TAPS_W-1:0] TAPS_RESET = 4'd8;

  typedef logic [KIND_W-1:0]          kind_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [IDX_W-1:0]           idx_t;
  typedef logic signed [LOAD_W-1:0]   load_t;
  typedef logic [OFF_W-1:0]           off_t;
  typedef logic signed [MAT_W-1:0]    mat_t;
  typedef logic signed [DEV_W-1:0]    dev_t;
  typedef logic signed [SCORE_W-1:0]  score_t;

  localparam kind_t KIND_SAMPLE = 2'd0;
  localparam kind_t KIND_MEAN   = 2'd1;
  localparam kind_t KIND_MATRIX = 2'd2;
  localparam kind_t KIND_OFFSET = 2'd3;

endpackage
`default_nettype wire

FILE: rtl/sms_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Input channel of the score unit: samples and table loads.
interface sms_in_if;
  logic                valid;
  logic                ready;
  sms_pkg::kind_t      kind;
  sms_pkg::sample_t    sample_value;
  sms_pkg::idx_t       row_index;
  sms_pkg::idx_t       col_index;
  sms_pkg::load_t      load_value;

  modport source (
    output valid, kind, sample_value, row_index, col_index, load_value,
    input  ready
  );
  modport sink (
    input  valid, kind, sample_value, row_index, col_index, load_value,
    output ready
  );
endinterface
`default_nettype wire

FILE: rtl/sms_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Result channel of the score unit.
interface sms_out_if;
  logic            valid;
  logic            ready;
  sms_pkg::score_t score;
  logic            warm;

  modport source (output valid, score, warm, input ready);
  modport sink (input valid, score, warm, output ready);
endinterface
`default_nettype wire

FILE: rtl/sms_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// Generic single-write, single-read RAM with registered read data.
module sms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: rtl/sliding_mahalanobis_score_unit.sv
// Load items (mean, matrix, offset) produce no result and leave the input ready.
// A sample item passes DEV, DEVW, QUAD, QDRAIN and FIN to a result, n being the taps in use:
// DEV reads one history entry per tap, then in QUAD one shared multiply-accumulate
// pipeline walks the n*n matrix terms one per cycle; a cold window skips that pass.
// Input stays busy after a sample until FIN loads its result, which waits on a held output.
// Sync reset clears mean, history pointer, sample count and matrix valid bits; offset k gets k.
`timescale 1ns / 1ps
`default_nettype none
module sliding_mahalanobis_score_unit #(
  parameter int TAPS_MAX      = 8,
  parameter int HISTORY_DEPTH = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  sms_in_if.sink                           in_ch,
  sms_out_if.source                        out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [sms_pkg::TAPS_W-1:0]  cfg_wdata
);

  localparam int IW     = (TAPS_MAX > 1) ? $clog2(TAPS_MAX) : 1;
  localparam int NW     = $clog2(TAPS_MAX + 1);
  localparam int MDEPTH = TAPS_MAX * TAPS_MAX;
  localparam int MAW    = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
  localparam int HAW    = $clog2(HISTORY_DEPTH);
  localparam int SW     = $clog2(HISTORY_DEPTH + 1);
  localparam int CW     = ((HAW > sms_pkg::OFF_W) ? HAW : sms_pkg::OFF_W) + 1;
  localparam int PW     = 2 * sms_pkg::DEV_W;
  localparam int TW     = PW + sms_pkg::MAT_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DEV    = 3'd1;
  localparam logic [2:0] S_DEVW   = 3'd2;
  localparam logic [2:0] S_QUAD   = 3'd3;
  localparam logic [2:0] S_QDRAIN = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0]                  state_r;
  logic [sms_pkg::TAPS_W-1:0]  taps_r;
  logic [HAW-1:0]              wp_r;
  logic [HAW-1:0]              wp_nxt;
  logic [SW-1:0]               seen_r;
  sms_pkg::sample_t            mean_r [TAPS_MAX];
  sms_pkg::off_t               off_r [TAPS_MAX];
  logic [MDEPTH-1:0]           mvalid_r;
  logic [IW-1:0]               i_r;
  logic [IW-1:0]               j_r;
  logic                        dv_r;
  logic [IW-1:0]               dj_r;
  sms_pkg::dev_t               d_r [TAPS_MAX];
  sms_pkg::dev_t               di_r;
  sms_pkg::dev_t               dnext_r;
  sms_pkg::dev_t               dnext_nxt;
  sms_pkg::off_t               maxoff_r;
  logic                        warm_r;
  logic                        s1_v_r;
  logic                        s2_v_r;
  logic signed [PW-1:0]        p_r;
  logic                        mv_rd_r;
  logic signed [TW-1:0]        prod_r;
  sms_pkg::score_t             acc_r;
  logic                        out_valid_r;
  sms_pkg::score_t             out_score_r;
  logic                        out_warm_r;

  logic                        in_fire;
  logic                        row_ok;
  logic                        col_ok;
  logic [NW-1:0]               n_taps;
  logic                        last_j;
  logic                        last_i;
  sms_pkg::off_t               off_cur;
  sms_pkg::off_t               off_eff;
  logic [CW-1:0]               hdiff;
  logic [HAW-1:0]              h_raddr;
  logic [sms_pkg::SAMPLE_W-1:0] h_rdata;
  logic                        h_we;
  logic                        m_we;
  logic [MAW-1:0]              m_waddr;
  logic [MAW-1:0]              m_raddr;
  logic [sms_pkg::MAT_W-1:0]   m_rdata;
  sms_pkg::dev_t               dev_cap;
  sms_pkg::dev_t               d_j;
  sms_pkg::mat_t               mat_sel;
  logic                        warm_now;
  logic                        fin_load;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  assign row_ok = int'(in_ch.row_index) < TAPS_MAX;
  assign col_ok = int'(in_ch.col_index) < TAPS_MAX;

  always_comb begin
    if (taps_r == '0) begin
      n_taps = NW'(1);
    end else if (int'(taps_r) > TAPS_MAX) begin
      n_taps = NW'(TAPS_MAX);
    end else begin
      n_taps = NW'(taps_r);
    end
  end

  assign last_j = (int'(j_r) == int'(n_taps) - 1);
  assign last_i = (int'(i_r) == int'(n_taps) - 1);

  assign wp_nxt = (wp_r == HAW'(HISTORY_DEPTH - 1)) ? '0 : wp_r + 1'b1;

  // The tap at offset k sits k entries behind the newest history slot.
  assign off_cur = off_r[j_r];
  assign off_eff = (int'(off_cur) < HISTORY_DEPTH) ? off_cur : '0;
  assign hdiff   = CW'(wp_r) - CW'(off_eff);
  assign h_raddr = hdiff[CW-1] ? HAW'(hdiff + CW'(HISTORY_DEPTH)) : HAW'(hdiff);
  assign h_we    = in_fire && (in_ch.kind == sms_pkg::KIND_SAMPLE);

  sms_ram #(
    .WIDTH (sms_pkg::SAMPLE_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (wp_nxt),
    .wdata (in_ch.sample_value),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  assign m_we    = in_fire && (in_ch.kind == sms_pkg::KIND_MATRIX) && row_ok && col_ok;
  assign m_waddr = MAW'(int'(in_ch.row_index) * TAPS_MAX + int'(in_ch.col_index));
  assign m_raddr = MAW'(int'(i_r) * TAPS_MAX + int'(j_r));

  sms_ram #(
    .WIDTH (sms_pkg::MAT_W),
    .DEPTH (MDEPTH)
  ) u_mat_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (in_ch.load_value),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  assign dev_cap   = sms_pkg::dev_t'(sms_pkg::sample_t'(h_rdata))
                     - sms_pkg::dev_t'(mean_r[dj_r]);
  assign d_j       = d_r[j_r];
  assign dnext_nxt = (int'(j_r) == int'(i_r) + 1) ? d_j : dnext_r;
  assign mat_sel   = mv_rd_r ? sms_pkg::mat_t'(m_rdata) : '0;
  assign warm_now  = (int'(maxoff_r) < HISTORY_DEPTH) && (int'(seen_r) > int'(maxoff_r));
  assign fin_load  = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      taps_r      <= sms_pkg::TAPS_RESET;
      wp_r        <= '0;
      seen_r      <= '0;
      mvalid_r    <= '0;
      i_r         <= '0;
      j_r         <= '0;
      dv_r        <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < TAPS_MAX; k++) begin
        mean_r[k] <= '0;
        off_r[k]  <= sms_pkg::OFF_W'(k);
      end
    end else begin
      if (cfg_we) begin
        taps_r <= cfg_wdata;
      end
      if (m_we) begin
        mvalid_r[m_waddr] <= 1'b1;
      end
      if (in_fire && (in_ch.kind == sms_pkg::KIND_MEAN) && row_ok) begin
        mean_r[IW'(in_ch.row_index)] <= in_ch.load_value[sms_pkg::SAMPLE_W-1:0];
      end
      if (in_fire && (in_ch.kind == sms_pkg::KIND_OFFSET) && row_ok) begin
        off_r[IW'(in_ch.row_index)] <= in_ch.load_value[sms_pkg::OFF_W-1:0];
      end
      if (h_we) begin
        wp_r <= wp_nxt;
        if (int'(seen_r) < HISTORY_DEPTH) begin
          seen_r <= seen_r + 1'b1;
        end
      end

      dv_r   <= (state_r == S_DEV);
      s1_v_r <= (state_r == S_QUAD);
      s2_v_r <= s1_v_r;

      if (fin_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          i_r <= '0;
          j_r <= '0;
          if (h_we) begin
            state_r <= S_DEV;
          end
        end
        S_DEV: begin
          if (last_j) begin
            j_r     <= '0;
            state_r <= S_DEVW;
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        S_DEVW: begin
          if (!dv_r) begin
            state_r <= warm_now ? S_QUAD : S_FIN;
          end
        end
        S_QUAD: begin
          if (last_j) begin
            j_r <= '0;
            if (last_i) begin
              state_r <= S_QDRAIN;
            end else begin
              i_r <= i_r + 1'b1;
            end
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        S_QDRAIN: begin
          if (!s1_v_r && !s2_v_r) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_load) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (h_we) begin
      maxoff_r <= '0;
      acc_r    <= '0;
    end
    if (state_r == S_DEV) begin
      dj_r <= j_r;
      if (off_cur > maxoff_r) begin
        maxoff_r <= off_cur;
      end
    end
    if (dv_r) begin
      d_r[dj_r] <= dev_cap;
      if (dj_r == '0) begin
        di_r <= dev_cap;
      end
    end
    if ((state_r == S_DEVW) && !dv_r) begin
      warm_r <= warm_now;
    end
    // Row i+1's deviation is picked up while row i walks past it.
    if (state_r == S_QUAD) begin
      p_r     <= di_r * d_j;
      dnext_r <= dnext_nxt;
      if (last_j && !last_i) begin
        di_r <= dnext_nxt;
      end
    end
    mv_rd_r <= mvalid_r[m_raddr];
    prod_r  <= mat_sel * p_r;
    if (s2_v_r) begin
      acc_r <= acc_r + sms_pkg::SCORE_W'(prod_r);
    end
    if (fin_load) begin
      out_score_r <= warm_r ? acc_r : '0;
      out_warm_r  <= warm_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.score = out_score_r;
  assign out_ch.warm  = out_warm_r;

endmodule
`default_nettype wire

FILE: rtl/sms_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks of the score unit and their attachment to the top level.
module sms_checker (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            in_valid,
  input wire logic            in_ready,
  input wire sms_pkg::kind_t  in_kind,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire sms_pkg::score_t out_score,
  input wire logic            out_warm
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_score) && $stable(out_warm))
    else $error("Result item changed while stalled.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid after reset.");

  a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_kind != sms_pkg::KIND_SAMPLE) |=> in_ready)
    else $error("Load item did not complete in one cycle.");

  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_kind == sms_pkg::KIND_SAMPLE) |=> !in_ready)
    else $error("Block ready right after taking a sample item.");

  a_cold_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_warm |-> out_score == '0)
    else $error("Cold result carries a nonzero score.");

endmodule

bind sliding_mahalanobis_score_unit sms_checker u_sms_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_kind   (in_ch.kind),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_score (out_ch.score),
  .out_warm  (out_ch.warm)
);
`default_nettype wire
